FILE: hdl/brf_pkg.sv
// Shared types, constants and saturation helpers for the Brent root finder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package brf_pkg;

  localparam int VW = 50;
  localparam int MW = 47;
  localparam int QW = MW + 16;
  localparam int CW = 25;

  localparam logic signed [VW-1:0] LIM    = VW'((64'd1 << MW) - 64'd1);
  localparam logic signed [VW-1:0] ONE    = VW'(64'sd65536);
  localparam logic signed [VW-1:0] I32MAX = VW'(64'sd2147483647);
  localparam logic signed [VW-1:0] I32MIN = VW'(-64'sd2147483648);

  localparam logic [1:0] KIND_EVAL  = 2'd0;
  localparam logic [1:0] KIND_ROOT  = 2'd1;
  localparam logic [1:0] KIND_NOBRK = 2'd2;
  localparam logic [1:0] KIND_ITER  = 2'd3;

  localparam logic [1:0] CFG_TOL   = 2'd0;
  localparam logic [1:0] CFG_WIDEN = 2'd1;
  localparam logic [1:0] CFG_TRIES = 2'd2;
  localparam logic [1:0] CFG_ITERS = 2'd3;

  typedef logic [5:0] op_t;

  localparam op_t OP_NOP    = 6'd0;
  localparam op_t OP_LOAD   = 6'd1;
  localparam op_t OP_START  = 6'd2;
  localparam op_t OP_SETFA  = 6'd3;
  localparam op_t OP_WIDEN  = 6'd4;
  localparam op_t OP_SETFB  = 6'd5;
  localparam op_t OP_BRK    = 6'd6;
  localparam op_t OP_NEXTIT = 6'd7;
  localparam op_t OP_IT1    = 6'd8;
  localparam op_t OP_IT2    = 6'd9;
  localparam op_t OP_M      = 6'd10;
  localparam op_t OP_BIS    = 6'd11;
  localparam op_t OP_Q0     = 6'd12;
  localparam op_t OP_PQ     = 6'd13;
  localparam op_t OP_RL     = 6'd14;
  localparam op_t OP_STEP   = 6'd15;
  localparam op_t OP_OUT_A  = 6'd16;
  localparam op_t OP_OUT_B  = 6'd17;
  localparam op_t OP_OUT_Z  = 6'd18;
  localparam op_t OP_MD_S   = 6'd19;
  localparam op_t OP_MD_P0  = 6'd20;
  localparam op_t OP_MD_QA  = 6'd21;
  localparam op_t OP_MD_R   = 6'd22;
  localparam op_t OP_MD_T1A = 6'd23;
  localparam op_t OP_MD_T1B = 6'd24;
  localparam op_t OP_MD_T2  = 6'd25;
  localparam op_t OP_MD_P   = 6'd26;
  localparam op_t OP_MD_Q1  = 6'd27;
  localparam op_t OP_MD_Q2  = 6'd28;
  localparam op_t OP_MD_RA  = 6'd29;
  localparam op_t OP_MD_RB  = 6'd30;
  localparam op_t OP_MD_RC  = 6'd31;
  localparam op_t OP_MD_DQ  = 6'd32;

  typedef struct packed {
    logic               start_req;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic signed [31:0] func_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] point;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] kind;
    logic       md_start;
  } cmd_t;

  typedef struct packed {
    logic bracketed;
    logic try_ok;
    logic maxit_zero;
    logic iter_done;
    logic conv;
    logic bisect;
    logic ac_eq;
    logic accept;
    logic md_done;
  } status_t;

  function automatic logic signed [VW-1:0] sat_v(input logic signed [VW-1:0] x);
    if (x > LIM) return LIM;
    else if (x < -LIM) return -LIM;
    return x;
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [VW-1:0] x);
    if (x > I32MAX) return 32'sh7FFF_FFFF;
    else if (x < I32MIN) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [VW-1:0] abs_v(input logic signed [VW-1:0] x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [VW-1:0] ext32(input logic signed [31:0] x);
    return {{(VW-32){x[31]}}, x};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/brf_muldiv.sv
// Shared iterative Q16.16 multiply / divide unit, one bit per cycle.
// Depends on brf_pkg for widths, saturation limit and helpers.
`default_nettype none
module brf_muldiv (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           is_div,
  input  wire logic signed [brf_pkg::VW-1:0]  x,
  input  wire logic signed [brf_pkg::VW-1:0]  y,
  output logic                                done,
  output logic signed [brf_pkg::VW-1:0]       res
);
  localparam int MW = brf_pkg::MW;
  localparam int QW = brf_pkg::QW;
  localparam int PW = MW + 32;

  logic              busy_r, div_r, neg_r, done_r;
  logic [6:0]        cnt_r;
  logic [MW-1:0]     a_r;
  logic [MW:0]       hi_r;
  logic [QW-1:0]     lo_r;
  logic signed [brf_pkg::VW-1:0] res_r;

  logic signed [brf_pkg::VW-1:0] xs, ys;
  logic [MW-1:0]     ux, uy;
  logic [MW+1:0]     sum;
  logic [MW:0]       trial;
  logic              ge;
  logic [PW-1:0]     prod;
  logic [brf_pkg::VW-1:0] r_mag;

  always_comb begin
    xs    = brf_pkg::sat_v(x);
    ys    = brf_pkg::sat_v(y);
    ux    = MW'(brf_pkg::abs_v(xs));
    uy    = MW'(brf_pkg::abs_v(ys));
    sum   = {1'b0, hi_r} + (lo_r[0] ? {2'b00, a_r} : '0);
    trial = {hi_r[MW-1:0], lo_r[QW-1]};
    ge    = trial >= {1'b0, a_r};
    prod  = {hi_r, lo_r[MW-1:16]};
    if (div_r) begin
      r_mag = (lo_r > QW'(brf_pkg::LIM)) ? brf_pkg::LIM : brf_pkg::VW'(lo_r);
    end else begin
      r_mag = (prod > PW'(brf_pkg::LIM)) ? brf_pkg::LIM : brf_pkg::VW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        div_r <= is_div;
        neg_r <= x[brf_pkg::VW-1] ^ y[brf_pkg::VW-1];
        hi_r  <= '0;
        if (is_div && uy == '0) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
          if (xs > 0) res_r <= brf_pkg::LIM;
          else if (xs < 0) res_r <= -brf_pkg::LIM;
          else res_r <= '0;
        end else if (is_div) begin
          busy_r <= 1'b1;
          a_r    <= uy;
          lo_r   <= {ux, 16'b0};
          cnt_r  <= 7'(QW);
        end else begin
          busy_r <= 1'b1;
          a_r    <= ux;
          lo_r   <= {16'b0, uy};
          cnt_r  <= 7'(MW);
        end
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 7'd1;
          if (div_r) begin
            hi_r <= ge ? (trial - {1'b0, a_r}) : trial;
            lo_r <= {lo_r[QW-2:0], ge};
          end else begin
            hi_r          <= sum[MW+1:1];
            lo_r[MW-1:0]  <= {sum[0], lo_r[MW-1:1]};
          end
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= neg_r ? -$signed(r_mag) : $signed(r_mag);
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

FILE: hdl/brf_dp.sv
// Datapath of the Brent root finder: bracket state, temporaries, settings and output register.
// Depends on brf_pkg and brf_muldiv; driven by commands from brf_ctrl.
`default_nettype none
module brf_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [brf_pkg::CW-1:0] cfg_data,
  input  wire brf_pkg::in_item_t     in_data,
  input  wire brf_pkg::cmd_t         cmd,
  output brf_pkg::status_t           status,
  output brf_pkg::out_item_t         out_data
);
  localparam int VW = brf_pkg::VW;

  logic [15:0]              tol_r, max_iter_r, iter_r;
  logic [brf_pkg::CW-1:0]   widen_r;
  logic [3:0]               max_tries_r, try_r;

  logic signed [31:0] a_r, b_r, c_r, d_r, e_r, fa_r, fb_r, fc_r, fv_r, eo_r;
  logic signed [31:0] lb_r, ub_r;
  logic signed [VW-1:0] m_r, s_r, qa_r, rr_r, p_r, q_r, t1_r, t2_r, t3_r, x_r, y_r;
  brf_pkg::out_item_t out_r;

  logic signed [VW-1:0] tolv, wsv, diff, m_sum, stepv, md_x, md_y, md_res;
  logic                 md_div, md_done;

  brf_muldiv u_md (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.md_start),
    .is_div (md_div),
    .x      (md_x),
    .y      (md_y),
    .done   (md_done),
    .res    (md_res)
  );

  always_comb begin
    tolv  = $signed({{(VW-16){1'b0}}, tol_r});
    wsv   = $signed({{(VW-brf_pkg::CW){1'b0}}, widen_r});
    diff  = brf_pkg::ext32(c_r) - brf_pkg::ext32(b_r);
    m_sum = diff + $signed({{(VW-1){1'b0}}, diff[VW-1]});
    if (brf_pkg::abs_v(brf_pkg::ext32(d_r)) > tolv) stepv = brf_pkg::ext32(d_r);
    else stepv = (m_r > 0) ? tolv : -tolv;
  end

  always_comb begin
    md_div = 1'b0;
    md_x   = '0;
    md_y   = '0;
    case (cmd.op)
      brf_pkg::OP_MD_S: begin
        md_div = 1'b1;
        md_x   = brf_pkg::ext32(fb_r);
        md_y   = brf_pkg::ext32(fa_r);
      end
      brf_pkg::OP_MD_P0: begin
        md_x = m_r + m_r;
        md_y = s_r;
      end
      brf_pkg::OP_MD_QA: begin
        md_div = 1'b1;
        md_x   = brf_pkg::ext32(fa_r);
        md_y   = brf_pkg::ext32(fc_r);
      end
      brf_pkg::OP_MD_R: begin
        md_div = 1'b1;
        md_x   = brf_pkg::ext32(fb_r);
        md_y   = brf_pkg::ext32(fc_r);
      end
      brf_pkg::OP_MD_T1A: begin
        md_x = m_r + m_r;
        md_y = qa_r;
      end
      brf_pkg::OP_MD_T1B: begin
        md_x = t1_r;
        md_y = qa_r - rr_r;
      end
      brf_pkg::OP_MD_T2: begin
        md_x = brf_pkg::ext32(b_r) - brf_pkg::ext32(a_r);
        md_y = rr_r - brf_pkg::ONE;
      end
      brf_pkg::OP_MD_P: begin
        md_x = s_r;
        md_y = t1_r - t2_r;
      end
      brf_pkg::OP_MD_Q1: begin
        md_x = qa_r - brf_pkg::ONE;
        md_y = rr_r - brf_pkg::ONE;
      end
      brf_pkg::OP_MD_Q2: begin
        md_x = t1_r;
        md_y = s_r - brf_pkg::ONE;
      end
      brf_pkg::OP_MD_RA: begin
        md_x = m_r + m_r + m_r;
        md_y = q_r;
      end
      brf_pkg::OP_MD_RB: begin
        md_x = tolv;
        md_y = q_r;
      end
      brf_pkg::OP_MD_RC: begin
        md_x = brf_pkg::ext32(eo_r);
        md_y = q_r;
      end
      brf_pkg::OP_MD_DQ: begin
        md_div = 1'b1;
        md_x   = p_r;
        md_y   = q_r;
      end
      default: begin
        md_div = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= 16'd1;
      widen_r     <= 25'd655360;
      max_tries_r <= 4'd5;
      max_iter_r  <= 16'd1000;
      try_r       <= '0;
      iter_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          brf_pkg::CFG_TOL:   tol_r       <= cfg_data[15:0];
          brf_pkg::CFG_WIDEN: widen_r     <= cfg_data;
          brf_pkg::CFG_TRIES: max_tries_r <= cfg_data[3:0];
          brf_pkg::CFG_ITERS: max_iter_r  <= cfg_data[15:0];
          default:            tol_r       <= tol_r;
        endcase
      end
      case (cmd.op)
        brf_pkg::OP_START: begin
          try_r  <= '0;
          iter_r <= '0;
        end
        brf_pkg::OP_WIDEN:  try_r  <= try_r + 4'd1;
        brf_pkg::OP_BRK:    iter_r <= '0;
        brf_pkg::OP_NEXTIT: iter_r <= iter_r + 16'd1;
        default:            iter_r <= iter_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= '0;
      b_r  <= '0;
      c_r  <= '0;
      d_r  <= '0;
      e_r  <= '0;
      fa_r <= '0;
      fb_r <= '0;
      fc_r <= '0;
    end else begin
      case (cmd.op)
        brf_pkg::OP_LOAD: begin
          fv_r <= in_data.func_value;
          lb_r <= in_data.lower_bound;
          ub_r <= in_data.upper_bound;
        end
        brf_pkg::OP_START: begin
          a_r <= lb_r;
          b_r <= ub_r;
        end
        brf_pkg::OP_SETFA: fa_r <= fv_r;
        brf_pkg::OP_WIDEN: begin
          a_r  <= brf_pkg::sat_32(brf_pkg::ext32(a_r) - wsv);
          b_r  <= brf_pkg::sat_32(brf_pkg::ext32(b_r) + wsv);
          fb_r <= fv_r;
        end
        brf_pkg::OP_SETFB:  fb_r <= fv_r;
        brf_pkg::OP_NEXTIT: fb_r <= fv_r;
        brf_pkg::OP_BRK: begin
          fb_r <= fv_r;
          fc_r <= fv_r;
        end
        brf_pkg::OP_IT1: begin
          if ((fb_r > 0 && fc_r > 0) || (fb_r < 0 && fc_r < 0)) begin
            c_r  <= a_r;
            fc_r <= fa_r;
            d_r  <= brf_pkg::sat_32(brf_pkg::ext32(b_r) - brf_pkg::ext32(a_r));
            e_r  <= brf_pkg::sat_32(brf_pkg::ext32(b_r) - brf_pkg::ext32(a_r));
          end
        end
        brf_pkg::OP_IT2: begin
          if (brf_pkg::abs_v(brf_pkg::ext32(fc_r)) < brf_pkg::abs_v(brf_pkg::ext32(fb_r))) begin
            a_r  <= b_r;
            b_r  <= c_r;
            c_r  <= b_r;
            fa_r <= fb_r;
            fb_r <= fc_r;
            fc_r <= fb_r;
          end
        end
        brf_pkg::OP_M: m_r <= m_sum >>> 1;
        brf_pkg::OP_BIS: begin
          d_r <= m_r[31:0];
          e_r <= m_r[31:0];
        end
        brf_pkg::OP_Q0: q_r <= brf_pkg::sat_v(brf_pkg::ONE - s_r);
        brf_pkg::OP_PQ: begin
          if (p_r > 0) q_r <= -q_r;
          else p_r <= -p_r;
          eo_r <= e_r;
          e_r  <= d_r;
        end
        brf_pkg::OP_RL: begin
          x_r <= t1_r - brf_pkg::abs_v(t2_r);
          y_r <= brf_pkg::abs_v(t3_r) >>> 1;
        end
        brf_pkg::OP_STEP: begin
          a_r  <= b_r;
          fa_r <= fb_r;
          b_r  <= brf_pkg::sat_32(brf_pkg::ext32(b_r) + stepv);
        end
        brf_pkg::OP_OUT_A: begin
          out_r.kind  <= cmd.kind;
          out_r.point <= a_r;
        end
        brf_pkg::OP_OUT_B: begin
          out_r.kind  <= cmd.kind;
          out_r.point <= b_r;
        end
        brf_pkg::OP_OUT_Z: begin
          out_r.kind  <= cmd.kind;
          out_r.point <= '0;
        end
        default: begin
          if (md_done) begin
            case (cmd.op)
              brf_pkg::OP_MD_S:   s_r  <= md_res;
              brf_pkg::OP_MD_P0:  p_r  <= md_res;
              brf_pkg::OP_MD_QA:  qa_r <= md_res;
              brf_pkg::OP_MD_R:   rr_r <= md_res;
              brf_pkg::OP_MD_T1A: t1_r <= md_res;
              brf_pkg::OP_MD_T1B: t1_r <= md_res;
              brf_pkg::OP_MD_T2:  t2_r <= md_res;
              brf_pkg::OP_MD_P:   p_r  <= md_res;
              brf_pkg::OP_MD_Q1:  t1_r <= md_res;
              brf_pkg::OP_MD_Q2:  q_r  <= md_res;
              brf_pkg::OP_MD_RA:  t1_r <= md_res;
              brf_pkg::OP_MD_RB:  t2_r <= md_res;
              brf_pkg::OP_MD_RC:  t3_r <= md_res;
              brf_pkg::OP_MD_DQ:  d_r  <= brf_pkg::sat_32(md_res);
              default:            s_r  <= s_r;
            endcase
          end
        end
      endcase
    end
  end

  always_comb begin
    status.bracketed  = (fa_r > 0 && fv_r < 0) || (fa_r < 0 && fv_r > 0);
    status.try_ok     = try_r < max_tries_r;
    status.maxit_zero = max_iter_r == '0;
    status.iter_done  = iter_r >= max_iter_r;
    status.conv       = (brf_pkg::abs_v(m_r) <= tolv) || (fb_r == 0);
    status.bisect     = (brf_pkg::abs_v(brf_pkg::ext32(e_r)) < tolv) ||
                        (brf_pkg::abs_v(brf_pkg::ext32(fa_r)) <=
                         brf_pkg::abs_v(brf_pkg::ext32(fb_r)));
    status.ac_eq      = a_r == c_r;
    status.accept     = ((p_r + p_r) < x_r) && (p_r < y_r);
    status.md_done    = md_done;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

FILE: hdl/brf_ctrl.sv
// Sequencer of the Brent root finder: search phase, step order and output handshake.
// Depends on brf_pkg; issues commands to brf_dp and reads its status.
`default_nettype none
module brf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_start,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire brf_pkg::status_t  status,
  output brf_pkg::cmd_t          cmd
);
  localparam logic [4:0] ST_IN    = 5'd0;
  localparam logic [4:0] ST_DISP  = 5'd1;
  localparam logic [4:0] ST_ITCHK = 5'd2;
  localparam logic [4:0] ST_EMIT  = 5'd3;
  localparam logic [4:0] ST_I1    = 5'd4;
  localparam logic [4:0] ST_I2    = 5'd5;
  localparam logic [4:0] ST_M     = 5'd6;
  localparam logic [4:0] ST_CONV  = 5'd7;
  localparam logic [4:0] ST_S     = 5'd8;
  localparam logic [4:0] ST_P0    = 5'd9;
  localparam logic [4:0] ST_Q0    = 5'd10;
  localparam logic [4:0] ST_QA    = 5'd11;
  localparam logic [4:0] ST_R     = 5'd12;
  localparam logic [4:0] ST_T1A   = 5'd13;
  localparam logic [4:0] ST_T1B   = 5'd14;
  localparam logic [4:0] ST_T2    = 5'd15;
  localparam logic [4:0] ST_P     = 5'd16;
  localparam logic [4:0] ST_Q1    = 5'd17;
  localparam logic [4:0] ST_Q2    = 5'd18;
  localparam logic [4:0] ST_PQ    = 5'd19;
  localparam logic [4:0] ST_RA    = 5'd20;
  localparam logic [4:0] ST_RB    = 5'd21;
  localparam logic [4:0] ST_RC    = 5'd22;
  localparam logic [4:0] ST_RL    = 5'd23;
  localparam logic [4:0] ST_ACC   = 5'd24;
  localparam logic [4:0] ST_DQ    = 5'd25;
  localparam logic [4:0] ST_BIS   = 5'd26;
  localparam logic [4:0] ST_STEP  = 5'd27;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_WAIT_A  = 2'd1;
  localparam logic [1:0] PH_WAIT_B  = 2'd2;
  localparam logic [1:0] PH_WAIT_IT = 2'd3;

  logic [4:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             wait_r, wait_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             start_r, start_nxt;
  brf_pkg::op_t     emit_op_r, emit_op_nxt;
  logic [1:0]       emit_kind_r, emit_kind_nxt;
  logic             md_state, md_adv, out_acc;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    wait_nxt      = wait_r;
    start_nxt     = start_r;
    emit_op_nxt   = emit_op_r;
    emit_kind_nxt = emit_kind_r;
    out_acc       = out_valid_r && !out_stall;
    out_valid_nxt = out_valid_r && !out_acc;
    cmd.op        = brf_pkg::OP_NOP;
    cmd.kind      = emit_kind_r;
    cmd.md_start  = 1'b0;
    md_state      = state_r inside {ST_S, ST_P0, ST_QA, ST_R, ST_T1A, ST_T1B, ST_T2,
                                    ST_P, ST_Q1, ST_Q2, ST_RA, ST_RB, ST_RC, ST_DQ};
    md_adv        = wait_r && status.md_done;

    if (md_state) begin
      if (!wait_r) begin
        cmd.md_start = 1'b1;
        wait_nxt     = 1'b1;
      end else if (status.md_done) begin
        wait_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_IN: begin
        if (in_valid) begin
          cmd.op    = brf_pkg::OP_LOAD;
          start_nxt = in_start;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        state_nxt = ST_EMIT;
        if (start_r) begin
          cmd.op        = brf_pkg::OP_START;
          phase_nxt     = PH_WAIT_A;
          emit_op_nxt   = brf_pkg::OP_OUT_A;
          emit_kind_nxt = brf_pkg::KIND_EVAL;
        end else begin
          case (phase_r)
            PH_WAIT_A: begin
              cmd.op        = brf_pkg::OP_SETFA;
              phase_nxt     = PH_WAIT_B;
              emit_op_nxt   = brf_pkg::OP_OUT_B;
              emit_kind_nxt = brf_pkg::KIND_EVAL;
            end
            PH_WAIT_B: begin
              if (status.bracketed) begin
                cmd.op = brf_pkg::OP_BRK;
                if (status.maxit_zero) begin
                  phase_nxt     = PH_IDLE;
                  emit_op_nxt   = brf_pkg::OP_OUT_Z;
                  emit_kind_nxt = brf_pkg::KIND_ITER;
                end else begin
                  state_nxt = ST_I1;
                end
              end else if (status.try_ok) begin
                cmd.op        = brf_pkg::OP_WIDEN;
                phase_nxt     = PH_WAIT_A;
                emit_op_nxt   = brf_pkg::OP_OUT_A;
                emit_kind_nxt = brf_pkg::KIND_EVAL;
              end else begin
                cmd.op        = brf_pkg::OP_SETFB;
                phase_nxt     = PH_IDLE;
                emit_op_nxt   = brf_pkg::OP_OUT_Z;
                emit_kind_nxt = brf_pkg::KIND_NOBRK;
              end
            end
            PH_WAIT_IT: begin
              cmd.op    = brf_pkg::OP_NEXTIT;
              state_nxt = ST_ITCHK;
            end
            default: begin
              emit_op_nxt   = brf_pkg::OP_OUT_Z;
              emit_kind_nxt = brf_pkg::KIND_NOBRK;
            end
          endcase
        end
      end
      ST_ITCHK: begin
        if (status.iter_done) begin
          phase_nxt     = PH_IDLE;
          emit_op_nxt   = brf_pkg::OP_OUT_Z;
          emit_kind_nxt = brf_pkg::KIND_ITER;
          state_nxt     = ST_EMIT;
        end else begin
          state_nxt = ST_I1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_acc) begin
          cmd.op        = emit_op_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IN;
        end
      end
      ST_I1: begin
        cmd.op    = brf_pkg::OP_IT1;
        state_nxt = ST_I2;
      end
      ST_I2: begin
        cmd.op    = brf_pkg::OP_IT2;
        state_nxt = ST_M;
      end
      ST_M: begin
        cmd.op    = brf_pkg::OP_M;
        state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (status.conv) begin
          phase_nxt     = PH_IDLE;
          emit_op_nxt   = brf_pkg::OP_OUT_B;
          emit_kind_nxt = brf_pkg::KIND_ROOT;
          state_nxt     = ST_EMIT;
        end else if (status.bisect) begin
          state_nxt = ST_BIS;
        end else begin
          state_nxt = ST_S;
        end
      end
      ST_S: begin
        cmd.op = brf_pkg::OP_MD_S;
        if (md_adv) state_nxt = status.ac_eq ? ST_P0 : ST_QA;
      end
      ST_P0: begin
        cmd.op = brf_pkg::OP_MD_P0;
        if (md_adv) state_nxt = ST_Q0;
      end
      ST_Q0: begin
        cmd.op    = brf_pkg::OP_Q0;
        state_nxt = ST_PQ;
      end
      ST_QA: begin
        cmd.op = brf_pkg::OP_MD_QA;
        if (md_adv) state_nxt = ST_R;
      end
      ST_R: begin
        cmd.op = brf_pkg::OP_MD_R;
        if (md_adv) state_nxt = ST_T1A;
      end
      ST_T1A: begin
        cmd.op = brf_pkg::OP_MD_T1A;
        if (md_adv) state_nxt = ST_T1B;
      end
      ST_T1B: begin
        cmd.op = brf_pkg::OP_MD_T1B;
        if (md_adv) state_nxt = ST_T2;
      end
      ST_T2: begin
        cmd.op = brf_pkg::OP_MD_T2;
        if (md_adv) state_nxt = ST_P;
      end
      ST_P: begin
        cmd.op = brf_pkg::OP_MD_P;
        if (md_adv) state_nxt = ST_Q1;
      end
      ST_Q1: begin
        cmd.op = brf_pkg::OP_MD_Q1;
        if (md_adv) state_nxt = ST_Q2;
      end
      ST_Q2: begin
        cmd.op = brf_pkg::OP_MD_Q2;
        if (md_adv) state_nxt = ST_PQ;
      end
      ST_PQ: begin
        cmd.op    = brf_pkg::OP_PQ;
        state_nxt = ST_RA;
      end
      ST_RA: begin
        cmd.op = brf_pkg::OP_MD_RA;
        if (md_adv) state_nxt = ST_RB;
      end
      ST_RB: begin
        cmd.op = brf_pkg::OP_MD_RB;
        if (md_adv) state_nxt = ST_RC;
      end
      ST_RC: begin
        cmd.op = brf_pkg::OP_MD_RC;
        if (md_adv) state_nxt = ST_RL;
      end
      ST_RL: begin
        cmd.op    = brf_pkg::OP_RL;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = status.accept ? ST_DQ : ST_BIS;
      end
      ST_DQ: begin
        cmd.op = brf_pkg::OP_MD_DQ;
        if (md_adv) state_nxt = ST_STEP;
      end
      ST_BIS: begin
        cmd.op    = brf_pkg::OP_BIS;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.op        = brf_pkg::OP_STEP;
        phase_nxt     = PH_WAIT_IT;
        emit_op_nxt   = brf_pkg::OP_OUT_B;
        emit_kind_nxt = brf_pkg::KIND_EVAL;
        state_nxt     = ST_EMIT;
      end
      default: begin
        state_nxt = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IN;
      phase_r     <= PH_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
      emit_op_r   <= brf_pkg::OP_OUT_Z;
      emit_kind_r <= brf_pkg::KIND_EVAL;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      emit_op_r   <= emit_op_nxt;
      emit_kind_r <= emit_kind_nxt;
    end
  end

  assign in_stall  = state_r != ST_IN;
  assign out_valid = out_valid_r;

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IN && in_valid) |=> (state_r == ST_DISP))
    else $error("accepted transaction not dispatched");

  a_md_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r && !status.md_done) |=> $stable(state_r))
    else $error("sequencer advanced while arithmetic unit busy");

  a_md_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.md_start |=> (wait_r && !cmd.md_start))
    else $error("arithmetic unit restarted before completion");

  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_valid_r) |=> (out_valid_r && state_r == ST_IN))
    else $error("result not loaded into free output register");

endmodule
`default_nettype wire

FILE: hdl/brent_root_finder_unit.sv
// Top level of the Brent root finder: configuration port, controller and datapath.
// Depends on brf_pkg, brf_ctrl, brf_dp (and brf_muldiv inside brf_dp).
//
// Request and answer root finder on signed Q16.16 values. Each input transaction
// (a start with bounds, or the function value at the last requested point) yields
// exactly one result transaction: a point to evaluate, the root, or a failure code.
// A Brent iteration runs on one shared bit-serial multiply/divide unit; a bisection
// step is shortest, secant interpolation longer and inverse quadratic interpolation
// longest. One transaction is processed at a time; a new one is taken while the
// previous result still waits in the output register. Configuration writes are
// always ready.
`default_nettype none
module brent_root_finder_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire brf_pkg::in_item_t       in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output brf_pkg::out_item_t           out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [brf_pkg::CW-1:0]  cfg_data
);
  brf_pkg::cmd_t    cmd;
  brf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_start  (in_data.start_req),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  brf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for brent_root_finder_unit: drives searches against test functions.
// Depends on brf_pkg and the RTL of brent_root_finder_unit; predicts every result itself.
`timescale 1ns / 100ps
module tb;

  typedef enum logic [1:0] {SRCH_IDLE, SRCH_WAIT_LO, SRCH_WAIT_HI, SRCH_WAIT_IT} srch_phase_t;
  typedef enum int {FN_LINEAR, FN_CUBIC, FN_STEP, FN_NOROOT, FN_NOISE} fn_shape_t;

  localparam longint Q47 = 64'sh7FFF_FFFF_FFFF;
  localparam longint ONEQ = 65536;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  brf_pkg::in_item_t in_data;
  brf_pkg::out_item_t out_data;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [brf_pkg::CW-1:0] cfg_data;

  brent_root_finder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  longint tol_r, widen_r, tries_r, iters_r;
  longint ba, eb, cc, sd, pe, va, vb, vc;
  srch_phase_t sph;
  logic [3:0] try_cnt;
  logic [15:0] it_cnt;

  brf_pkg::out_item_t pending_q[$];
  int errors, items_sent, n_checked, n_roots, n_nobrk, n_iterlim;
  int burst_left;
  int stall_mode, stall_cnt;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clip47(longint x);
    return x > Q47 ? Q47 : (x < -Q47 ? -Q47 : x);
  endfunction

  function automatic longint clip32(longint x);
    return x > 64'sd2147483647 ? 64'sd2147483647 :
           (x < -64'sd2147483648 ? -64'sd2147483648 : x);
  endfunction

  function automatic longint magv(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint mul_q(longint x, longint y);
    longint unsigned ux, uy, r;
    ux = magv(clip47(x));
    uy = magv(clip47(y));
    if (ux != 0 && uy > 64'hFFFF_FFFF_FFFF_FFFF / ux) r = Q47;
    else begin
      r = (ux * uy) >> 16;
      if (r > Q47) r = Q47;
    end
    return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint div_q(longint x, longint y);
    longint unsigned ux, uy, r;
    x = clip47(x);
    y = clip47(y);
    if (y == 0) return x > 0 ? Q47 : (x < 0 ? -Q47 : 0);
    ux = magv(x);
    uy = magv(y);
    r = (ux << 16) / uy;
    if (r > Q47) r = Q47;
    return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic brf_pkg::out_item_t mk(logic [1:0] k, longint p);
    brf_pkg::out_item_t o;
    o.kind = k;
    o.point = p[31:0];
    return o;
  endfunction

  function automatic brf_pkg::out_item_t brent_iterate();
    longint tl, m, st, s, p, q, e_old, rhs, lim2, qa, r, t1, t2;
    tl = tol_r;
    if ((vb > 0 && vc > 0) || (vb < 0 && vc < 0)) begin
      cc = ba; vc = va; sd = clip32(eb - ba); pe = sd;
    end
    if (magv(vc) < magv(vb)) begin
      ba = eb; eb = cc; cc = ba; va = vb; vb = vc; vc = va;
    end
    m = (cc - eb) / 2;
    if (magv(m) <= tl || vb == 0) begin
      sph = SRCH_IDLE;
      return mk(brf_pkg::KIND_ROOT, eb);
    end
    if (magv(pe) < tl || magv(va) <= magv(vb)) begin
      sd = m; pe = m;
    end else begin
      s = div_q(vb, va);
      if (ba == cc) begin
        p = mul_q(2 * m, s);
        q = clip47(ONEQ - s);
      end else begin
        qa = div_q(va, vc);
        r = div_q(vb, vc);
        t1 = mul_q(mul_q(2 * m, qa), clip47(qa - r));
        t2 = mul_q(clip47(eb - ba), clip47(r - ONEQ));
        p = mul_q(s, clip47(t1 - t2));
        q = mul_q(mul_q(clip47(qa - ONEQ), clip47(r - ONEQ)), clip47(s - ONEQ));
      end
      if (p > 0) q = -q; else p = -p;
      e_old = pe;
      pe = sd;
      rhs = mul_q(3 * m, q) - magv(mul_q(tl, q));
      lim2 = magv(mul_q(e_old, q)) / 2;
      if (2 * p < rhs && p < lim2) sd = clip32(div_q(p, q));
      else begin
        sd = m; pe = m;
      end
    end
    ba = eb;
    va = vb;
    st = magv(sd) > tl ? sd : (m > 0 ? tl : -tl);
    eb = clip32(eb + st);
    sph = SRCH_WAIT_IT;
    return mk(brf_pkg::KIND_EVAL, eb);
  endfunction

  function automatic brf_pkg::out_item_t predict_answer(brf_pkg::in_item_t it);
    longint fv;
    fv = longint'(it.func_value);
    if (it.start_req) begin
      ba = longint'(it.lower_bound);
      eb = longint'(it.upper_bound);
      try_cnt = 0;
      it_cnt = 0;
      sph = SRCH_WAIT_LO;
      return mk(brf_pkg::KIND_EVAL, ba);
    end
    case (sph)
      SRCH_WAIT_LO: begin
        va = fv;
        sph = SRCH_WAIT_HI;
        return mk(brf_pkg::KIND_EVAL, eb);
      end
      SRCH_WAIT_HI: begin
        vb = fv;
        if (!((va > 0 && vb < 0) || (va < 0 && vb > 0))) begin
          if (try_cnt < tries_r) begin
            try_cnt = try_cnt + 1;
            ba = clip32(ba - widen_r);
            eb = clip32(eb + widen_r);
            sph = SRCH_WAIT_LO;
            return mk(brf_pkg::KIND_EVAL, ba);
          end
          sph = SRCH_IDLE;
          return mk(brf_pkg::KIND_NOBRK, 0);
        end
        vc = vb;
        it_cnt = 0;
        if (iters_r == 0) begin
          sph = SRCH_IDLE;
          return mk(brf_pkg::KIND_ITER, 0);
        end
        return brent_iterate();
      end
      SRCH_WAIT_IT: begin
        vb = fv;
        it_cnt = it_cnt + 1;
        if (it_cnt >= iters_r) begin
          sph = SRCH_IDLE;
          return mk(brf_pkg::KIND_ITER, 0);
        end
        return brent_iterate();
      end
      default: return mk(brf_pkg::KIND_NOBRK, 0);
    endcase
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt <= $urandom_range(20, 300);
    end else stall_cnt <= stall_cnt - 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= stall_cnt[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      brf_pkg::out_item_t want;
      n_checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d point=%0d", $time, out_data.kind,
                 out_data.point);
      end else begin
        want = pending_q.pop_front();
        if (out_data.kind !== want.kind) begin
          errors++;
          $display("%0t: kind mismatch expected %0d actual %0d", $time, want.kind,
                   out_data.kind);
        end
        if (out_data.point !== want.point) begin
          errors++;
          $display("%0t: point mismatch expected %0d actual %0d", $time, want.point,
                   out_data.point);
        end
        if (want.kind == brf_pkg::KIND_ROOT) n_roots++;
        if (want.kind == brf_pkg::KIND_NOBRK) n_nobrk++;
        if (want.kind == brf_pkg::KIND_ITER) n_iterlim++;
      end
    end
  end

  task automatic send_item(input brf_pkg::in_item_t it, output brf_pkg::out_item_t ans);
    int gap;
    ans = predict_answer(it);
    pending_q.push_back(ans);
    items_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input longint val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val[brf_pkg::CW-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      brf_pkg::CFG_TOL:   tol_r = val & 16'hFFFF;
      brf_pkg::CFG_WIDEN: widen_r = val & 25'h1FF_FFFF;
      brf_pkg::CFG_TRIES: tries_r = val & 4'hF;
      default:            iters_r = val & 16'hFFFF;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(longint tl, longint wd, longint tr, longint it);
    drain();
    write_reg(brf_pkg::CFG_TOL, tl);
    write_reg(brf_pkg::CFG_WIDEN, wd);
    write_reg(brf_pkg::CFG_TRIES, tr);
    write_reg(brf_pkg::CFG_ITERS, it);
  endtask

  function automatic logic signed [31:0] eval_fn(fn_shape_t shape, longint root, longint k,
                                                 bit neg, logic signed [31:0] x);
    longint d, v, nv;
    d = longint'(x) - root;
    case (shape)
      FN_LINEAR: v = (d * k) >>> 8;
      FN_CUBIC: begin
        d = d > 64'sd8388607 ? 64'sd8388607 : (d < -64'sd8388607 ? -64'sd8388607 : d);
        v = (((d * d) >>> 16) * d) >>> 16;
      end
      FN_STEP: v = d > 0 ? k * 1000 : (d < 0 ? -k * 1000 : 0);
      FN_NOROOT: v = 65536 + magv(d);
      default: v = {$urandom, $urandom};
    endcase
    v = clip32(v);
    if (shape == FN_NOISE) return v[31:0];
    nv = clip32(-v);
    return neg ? nv[31:0] : v[31:0];
  endfunction

  task automatic run_search(logic signed [31:0] lo, logic signed [31:0] hi, fn_shape_t shape,
                            longint root, int max_len);
    brf_pkg::in_item_t it;
    brf_pkg::out_item_t ans;
    longint k;
    bit neg;
    int n;
    k = $urandom_range(1, 512);
    neg = $urandom_range(0, 1);
    it.start_req = 1'b1;
    it.lower_bound = lo;
    it.upper_bound = hi;
    it.func_value = $urandom;
    send_item(it, ans);
    n = 0;
    while (ans.kind == brf_pkg::KIND_EVAL && n < max_len) begin
      it.start_req = 1'b0;
      it.lower_bound = $urandom;
      it.upper_bound = $urandom;
      it.func_value = eval_fn(shape, root, k, neg, ans.point);
      send_item(it, ans);
      n++;
    end
  endtask

  task automatic send_idle_value(logic signed [31:0] v);
    brf_pkg::in_item_t it;
    brf_pkg::out_item_t ans;
    it.start_req = 1'b0;
    it.lower_bound = $urandom;
    it.upper_bound = $urandom;
    it.func_value = v;
    send_item(it, ans);
  endtask

  task automatic test_directed();
    send_idle_value(32'sh7FFF_FFFF);
    send_idle_value(32'sh8000_0000);
    run_search(32'sh8000_0000, 32'sh7FFF_FFFF, FN_LINEAR, 12345, 80);
    run_search(-32'sd65536, 32'sd65536, FN_CUBIC, 0, 80);
    run_search(32'sd100000, 32'sd100000, FN_LINEAR, 100000, 20);
    run_search(32'sd0, 32'sd131072, FN_LINEAR, 0, 30);
    run_search(-32'sd500000, 32'sd700000, FN_STEP, 3333, 3);
    run_search(32'sd10, 32'sd20, FN_NOROOT, 0, 40);
    run_search(32'sh8000_0000, 32'sh7FFF_FFFF, FN_NOISE, 0, 6);
  endtask

  task automatic test_config_corners();
    configure(0, 0, 0, 0);
    run_search(-32'sd70000, 32'sd90000, FN_LINEAR, 5000, 20);
    run_search(32'sd10, 32'sd20, FN_NOROOT, 0, 20);
    configure(65535, 25'h1FF_FFFF, 15, 1);
    run_search(-32'sd1000000, 32'sd900000, FN_CUBIC, -7777, 20);
    run_search(32'sh8000_0000, 32'sh7FFF_FFFF, FN_NOROOT, 0, 40);
    configure(0, 24'hFF_FFFF, 15, 65535);
    run_search(-32'sd3000000, 32'sd2000000, FN_STEP, 4321, 200);
    run_search(32'sd5, 32'sd6, FN_NOROOT, 0, 40);
    configure(1, 16777216, 5, 2);
    run_search(-32'sd300000, 32'sd400000, FN_LINEAR, 999, 20);
  endtask

  task automatic test_random();
    longint root, span_lo, span_hi;
    int pick, since_cfg;
    fn_shape_t shape;
    since_cfg = 0;
    while (items_sent < 1650) begin
      if (since_cfg > 150) begin
        configure($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 64),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 33554431)
                                            : $urandom_range(0, 1 << 20),
                  $urandom_range(0, 15),
                  $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
                                            : $urandom_range(1, 80));
        since_cfg = 0;
      end
      pick = $urandom_range(0, 99);
      root = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      span_lo = $urandom_range(1, 1 << 22);
      span_hi = $urandom_range(1, 1 << 22);
      shape = pick < 40 ? FN_LINEAR : (pick < 65 ? FN_CUBIC : (pick < 85 ? FN_STEP
              : (pick < 92 ? FN_NOROOT : FN_NOISE)));
      if (pick >= 97) begin
        send_idle_value($urandom);
        since_cfg++;
      end else if (pick >= 92 || $urandom_range(0, 9) == 0)
        run_search($urandom, $urandom, shape, root, $urandom_range(1, 12));
      else
        run_search(32'(clip32(root - span_lo)), 32'(clip32(root + span_hi)), shape, root,
                   $urandom_range(0, 9) == 0 ? $urandom_range(1, 6) : 120);
      since_cfg += 8;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = brf_pkg::CFG_TOL;
    cfg_data = '0;
    stall_mode = 0;
    stall_cnt = 0;
    burst_left = 0;
    errors = 0;
    items_sent = 0;
    n_checked = 0;
    n_roots = 0;
    n_nobrk = 0;
    n_iterlim = 0;
    tol_r = 1; widen_r = 655360; tries_r = 5; iters_r = 1000;
    ba = 0; eb = 0; cc = 0; sd = 0; pe = 0; va = 0; vb = 0; vc = 0;
    sph = SRCH_IDLE;
    try_cnt = 0;
    it_cnt = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_corners();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d transactions, %0d results checked: %0d roots, %0d unbracketed,",
             items_sent, n_checked, n_roots, n_nobrk);
    $display("%0d iteration-limit failures, across several register settings", n_iterlim);
    if (errors == 0 && pending_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
